### rtl/core/cctk_pkg.sv
// cctk_pkg: shared widths, constants, codes and control structs of the
// cycle counter timekeeper. No dependencies; used by every file of the core.
package cctk_pkg;

   localparam int COUNTER_WIDTH_DEF = 64;
   localparam int IN_W    = 64;
   localparam int CMD_W   = 2;
   localparam int FREQ_W  = 32;
   localparam int SEC_W   = 63;
   localparam int NS_W    = 30;
   localparam int TOTAL_W = 64;
   localparam int DIV_W   = 64;
   localparam int FRAC_W  = 62;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [NS_W-1:0]   NS_PER_SECOND = 30'd1000000000;
   localparam logic [SEC_W-1:0]  SEC_MAX       = {SEC_W{1'b1}};
   localparam logic [FREQ_W-1:0] FREQ_RESET    = 32'd1000000;

   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INIT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SWITCH = 2'd2;

   localparam logic REG_FREQ    = 1'b0;
   localparam logic REG_PRESENT = 1'b1;

   typedef struct packed {
      logic clock_present;
      logic freq_zero;
   } cfg_status_type;

   typedef struct packed {
      logic set_last;
      logic clear_time;
      logic div_start;
      logic div_step;
      logic mul_frac;
      logic accum;
      logic mul_lo;
      logic mul_hi;
      logic total_add;
      logic out_load;
   } dp_cmd_type;

endpackage

### rtl/core/cctk_regs.sv
// cctk_regs: configuration registers behind the csr_ port.
// Depends on cctk_pkg.
module cctk_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cctk_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cctk_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cctk_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [cctk_pkg::FREQ_W-1:0]       frequency_hz,
   output cctk_pkg::cfg_status_type          cfg_status
);

   logic [cctk_pkg::FREQ_W-1:0] freq_ff, freq_in;
   logic                        present_ff, present_in;
   logic                        wr_en;
   logic                        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   // word index, byte offset bits ignored
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      freq_in    = freq_ff;
      present_in = present_ff;
      if (wr_en) begin
         case (reg_sel)
            cctk_pkg::REG_FREQ:    freq_in    = csr_pwdata;
            cctk_pkg::REG_PRESENT: present_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff    <= cctk_pkg::FREQ_RESET;
         present_ff <= 1'b0;
      end else begin
         freq_ff    <= freq_in;
         present_ff <= present_in;
      end
   end

   always_comb begin
      case (reg_sel)
         cctk_pkg::REG_FREQ:    csr_prdata = freq_ff;
         cctk_pkg::REG_PRESENT: csr_prdata = {{(cctk_pkg::CSR_DATA_W-1){1'b0}}, present_ff};
         default:               csr_prdata = '0;
      endcase
   end

   assign frequency_hz             = freq_ff;
   assign cfg_status.clock_present = present_ff;
   assign cfg_status.freq_zero     = (freq_ff == '0);

endmodule

### rtl/core/cctk_ctrl.sv
// cctk_ctrl: sequencer for one item: command decode, divider step count,
// multiply steps and the result handshake. Depends on cctk_pkg.
module cctk_ctrl #(
   parameter int COUNTER_WIDTH = cctk_pkg::COUNTER_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cctk_pkg::CMD_W-1:0]    req_cmd,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  cctk_pkg::cfg_status_type      cfg_status,
   output cctk_pkg::dp_cmd_type          dp_cmd
);

   localparam int MAX_STEPS = (COUNTER_WIDTH > cctk_pkg::FRAC_W) ? COUNTER_WIDTH
                                                                  : cctk_pkg::FRAC_W;
   localparam int CNT_W = $clog2(MAX_STEPS);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DIV_Q  = 4'd1;
   localparam logic [3:0] ST_MUL_R  = 4'd2;
   localparam logic [3:0] ST_DIV_F  = 4'd3;
   localparam logic [3:0] ST_ACCUM  = 4'd4;
   localparam logic [3:0] ST_MUL_LO = 4'd5;
   localparam logic [3:0] ST_MUL_HI = 4'd6;
   localparam logic [3:0] ST_TOTAL  = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dp_cmd       = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_MUL_LO;
               case (req_cmd)
                  cctk_pkg::CMD_UPDATE: begin
                     if (cfg_status.clock_present) begin
                        dp_cmd.set_last = 1'b1;
                        if (!cfg_status.freq_zero) begin
                           dp_cmd.div_start = 1'b1;
                           cnt_in   = CNT_W'(COUNTER_WIDTH - 1);
                           state_in = ST_DIV_Q;
                        end
                     end
                  end
                  cctk_pkg::CMD_INIT: begin
                     dp_cmd.set_last   = 1'b1;
                     dp_cmd.clear_time = 1'b1;
                  end
                  cctk_pkg::CMD_SWITCH: dp_cmd.set_last = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_DIV_Q: begin
            dp_cmd.div_step = 1'b1;
            if (cnt_ff == '0) state_in = ST_MUL_R;
            else              cnt_in = cnt_ff - 1'b1;
         end
         ST_MUL_R: begin
            dp_cmd.mul_frac = 1'b1;
            cnt_in   = CNT_W'(cctk_pkg::FRAC_W - 1);
            state_in = ST_DIV_F;
         end
         ST_DIV_F: begin
            dp_cmd.div_step = 1'b1;
            if (cnt_ff == '0) state_in = ST_ACCUM;
            else              cnt_in = cnt_ff - 1'b1;
         end
         ST_ACCUM: begin
            dp_cmd.accum = 1'b1;
            state_in     = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            dp_cmd.mul_lo = 1'b1;
            state_in      = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            dp_cmd.mul_hi = 1'b1;
            state_in      = ST_TOTAL;
         end
         ST_TOTAL: begin
            dp_cmd.total_add = 1'b1;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.out_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/core/cctk_dp.sv
// cctk_dp: time state, bit-serial restoring divider, shared 32x30 multiplier
// by one billion and the result register. Depends on cctk_pkg.
module cctk_dp #(
   parameter int COUNTER_WIDTH = cctk_pkg::COUNTER_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cctk_pkg::dp_cmd_type            dp_cmd,
   input  logic [cctk_pkg::IN_W-1:0]       req_counter_value,
   input  logic [cctk_pkg::FREQ_W-1:0]     frequency_hz,
   output logic [cctk_pkg::SEC_W-1:0]      rsp_seconds,
   output logic [cctk_pkg::NS_W-1:0]       rsp_nanoseconds,
   output logic [cctk_pkg::TOTAL_W-1:0]    rsp_total_ns
);

   localparam int DIV_W  = cctk_pkg::DIV_W;
   localparam int FRAC_W = cctk_pkg::FRAC_W;
   localparam int FREQ_W = cctk_pkg::FREQ_W;
   localparam int SEC_W  = cctk_pkg::SEC_W;
   localparam int NS_W   = cctk_pkg::NS_W;
   localparam int TOT_W  = cctk_pkg::TOTAL_W;
   localparam int HALF_W = 32;

   logic [COUNTER_WIDTH-1:0] last_ff, last_in;
   logic [SEC_W-1:0]         sec_ff, sec_in;
   logic [NS_W-1:0]          ns_ff, ns_in;
   logic [DIV_W-1:0]         div_ff, div_in;
   logic [FREQ_W-1:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]         quo_ff, quo_in;
   logic [FRAC_W-1:0]        prod_ff, prod_in;
   logic [TOT_W-1:0]         total_ff, total_in;
   logic [SEC_W-1:0]         out_sec_ff, out_sec_in;
   logic [NS_W-1:0]          out_ns_ff, out_ns_in;
   logic [TOT_W-1:0]         out_total_ff, out_total_in;

   logic [COUNTER_WIDTH-1:0] now;
   logic [COUNTER_WIDTH-1:0] delta;
   logic [FREQ_W:0]          rem_sh;
   logic                     q_bit;
   logic [HALF_W-1:0]        mul_op;
   logic [FRAC_W-1:0]        mul_out;
   logic [NS_W:0]            ns_sum;
   logic                     ns_carry;
   logic [SEC_W+2:0]         sec_sum;

   assign now   = req_counter_value[COUNTER_WIDTH-1:0];
   assign delta = now - last_ff;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_sh = {rem_ff, div_ff[DIV_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, frequency_hz});

   always_comb begin
      if (dp_cmd.mul_frac)    mul_op = rem_ff;
      else if (dp_cmd.mul_lo) mul_op = sec_ff[HALF_W-1:0];
      else                    mul_op = HALF_W'(sec_ff[SEC_W-1:HALF_W]);
   end
   assign mul_out = FRAC_W'(mul_op) * FRAC_W'(cctk_pkg::NS_PER_SECOND);

   assign ns_sum   = {1'b0, ns_ff} + {1'b0, div_ff[NS_W-1:0]};
   assign ns_carry = (ns_sum >= {1'b0, cctk_pkg::NS_PER_SECOND});
   assign sec_sum  = (SEC_W+3)'(sec_ff) + (SEC_W+3)'(quo_ff) + (SEC_W+3)'(ns_carry);

   always_comb begin
      last_in      = last_ff;
      sec_in       = sec_ff;
      ns_in        = ns_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      prod_in      = prod_ff;
      total_in     = total_ff;
      out_sec_in   = out_sec_ff;
      out_ns_in    = out_ns_ff;
      out_total_in = out_total_ff;

      if (dp_cmd.set_last) last_in = now;
      if (dp_cmd.clear_time) begin
         sec_in = '0;
         ns_in  = '0;
      end
      if (dp_cmd.div_start) begin
         div_in = DIV_W'(delta) << (DIV_W - COUNTER_WIDTH);
         rem_in = '0;
      end
      if (dp_cmd.div_step) begin
         div_in = {div_ff[DIV_W-2:0], q_bit};
         rem_in = q_bit ? FREQ_W'(rem_sh - {1'b0, frequency_hz}) : rem_sh[FREQ_W-1:0];
      end
      if (dp_cmd.mul_frac) begin
         // whole seconds are parked, remainder times 1e9 becomes the dividend
         quo_in = div_ff;
         div_in = DIV_W'(mul_out) << (DIV_W - FRAC_W);
         rem_in = '0;
      end
      if (dp_cmd.accum) begin
         ns_in  = ns_carry ? NS_W'(ns_sum - {1'b0, cctk_pkg::NS_PER_SECOND})
                           : ns_sum[NS_W-1:0];
         sec_in = (sec_sum >= (SEC_W+3)'(cctk_pkg::SEC_MAX)) ? cctk_pkg::SEC_MAX
                                                              : sec_sum[SEC_W-1:0];
      end
      if (dp_cmd.mul_lo) prod_in = mul_out;
      if (dp_cmd.mul_hi) begin
         total_in = TOT_W'(prod_ff) + TOT_W'(ns_ff);
         prod_in  = mul_out;
      end
      if (dp_cmd.total_add) total_in = total_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
      if (dp_cmd.out_load) begin
         out_sec_in   = sec_ff;
         out_ns_in    = ns_ff;
         out_total_in = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         sec_ff  <= '0;
         ns_ff   <= '0;
      end else begin
         last_ff <= last_in;
         sec_ff  <= sec_in;
         ns_ff   <= ns_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      prod_ff      <= prod_in;
      total_ff     <= total_in;
      out_sec_ff   <= out_sec_in;
      out_ns_ff    <= out_ns_in;
      out_total_ff <= out_total_in;
   end

   assign rsp_seconds     = out_sec_ff;
   assign rsp_nanoseconds = out_ns_ff;
   assign rsp_total_ns    = out_total_ff;

endmodule

### rtl/core/cycle_counter_timekeeper_core.sv
// cycle_counter_timekeeper_core: top level of the cycle counter timekeeper.
// Depends on cctk_pkg, cctk_regs, cctk_ctrl and cctk_dp.
//
//  channel  | ports                                   | beat
//  ---------+-----------------------------------------+-----------------------------
//  request  | req_valid/ready, req_cmd, req_counter_*  | one command and reading
//  response | rsp_valid/ready, rsp_seconds/ns/total_ns | time after that command
//  csr      | csr_psel..csr_pready (APB-style)        | frequency_hz, clock_present
//
// an update with a clock source and nonzero frequency runs COUNTER_WIDTH divider
// steps for whole seconds, 62 for the fraction, then two multiply steps and an add
// for total_ns; every other item runs only those total_ns steps. one item is in
// work at a time; the next request is taken once the result sits in the output
// register, even if not yet taken.
// reset is synchronous and restores frequency 1 MHz, no clock source, zero time.
module cycle_counter_timekeeper_core #(
   parameter int COUNTER_WIDTH = cctk_pkg::COUNTER_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cctk_pkg::CMD_W-1:0]        req_cmd,
   input  logic [cctk_pkg::IN_W-1:0]         req_counter_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cctk_pkg::SEC_W-1:0]        rsp_seconds,
   output logic [cctk_pkg::NS_W-1:0]         rsp_nanoseconds,
   output logic [cctk_pkg::TOTAL_W-1:0]      rsp_total_ns,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cctk_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cctk_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cctk_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   logic [cctk_pkg::FREQ_W-1:0] frequency_hz;
   cctk_pkg::cfg_status_type    cfg_status;
   cctk_pkg::dp_cmd_type        dp_cmd;

   cctk_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .frequency_hz (frequency_hz),
      .cfg_status   (cfg_status)
   );

   cctk_ctrl #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cfg_status (cfg_status),
      .dp_cmd     (dp_cmd)
   );

   cctk_dp #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .req_counter_value (req_counter_value),
      .frequency_hz      (frequency_hz),
      .rsp_seconds       (rsp_seconds),
      .rsp_nanoseconds   (rsp_nanoseconds),
      .rsp_total_ns      (rsp_total_ns)
   );

endmodule

### rtl/core/cctk_checker.sv
// cctk_checker: port-level assertions for cycle_counter_timekeeper_core,
// attached by the bind below. Depends on cctk_pkg.
module cctk_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [cctk_pkg::SEC_W-1:0]      rsp_seconds,
   input logic [cctk_pkg::NS_W-1:0]       rsp_nanoseconds,
   input logic [cctk_pkg::TOTAL_W-1:0]    rsp_total_ns
);

   // nanoseconds stay within one second
   a_ns_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_nanoseconds < cctk_pkg::NS_PER_SECOND))
      else $error("rsp_nanoseconds out of range");

   // total matches seconds and nanoseconds of the same beat
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_total_ns == 64'(rsp_seconds) * 64'(cctk_pkg::NS_PER_SECOND)
                                     + 64'(rsp_nanoseconds)))
      else $error("rsp_total_ns inconsistent with seconds and nanoseconds");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an item is in work");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_seconds)
                                     && $stable(rsp_nanoseconds) && $stable(rsp_total_ns)))
      else $error("stalled result changed");

endmodule

bind cycle_counter_timekeeper_core cctk_checker u_cctk_checker (.*);
